[rtl/alqi_pkg.sv]
// ----------------------------------------------------------------------------
// alqi_pkg
// shared widths, constants and codes of the attitude lqi controller
// ----------------------------------------------------------------------------
package alqi_pkg;

    // field widths
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int DT_W       = 16;
    localparam int DT_FRAC    = 16;
    localparam int ERR_W      = DATA_W + 1;
    localparam int INTEG_W    = 48;
    localparam int THR_W      = 11;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_W       = 9 * DATA_W + DT_W;
    localparam int OUT_W      = 112;

    // digit serial multiplier geometry
    localparam int MAG_M_W    = 56;
    localparam int MAG_G_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = MAG_M_W / DIGIT_W;
    localparam int DCNT_W     = $clog2(NUM_DIGITS);
    localparam int PROD_W     = MAG_M_W + MAG_G_W;
    localparam int ACC_W      = 64;
    localparam int TERM_W     = 61;
    localparam int OPND_W     = MAG_G_W + 1;

    localparam int FRAC_BITS_DEF = 16;

    // saturation limits
    localparam logic [PROD_W-1:0] TERM_CAP = PROD_W'(1) << (TERM_W - 1);
    localparam logic signed [ACC_W-1:0] INTEG_MAX = (ACC_W'(1) << (INTEG_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] INTEG_MIN = -(ACC_W'(1) << (INTEG_W - 1));
    localparam logic signed [ACC_W-1:0] TORQ_MAX  = (ACC_W'(1) << (DATA_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] TORQ_MIN  = -(ACC_W'(1) << (DATA_W - 1));

    // throttle ramp
    localparam logic [THR_W-1:0] THR_START = 11'd1000;
    localparam logic [THR_W-1:0] THR_MAX   = 11'd1850;
    localparam logic [THR_W-1:0] THR_STEP  = 11'd3;
    localparam logic [THR_W-1:0] THR_ARM   = 11'd1020;

    // gain reset values
    localparam logic [GAIN_W-1:0] KI_RP_RST = 24'd1114112;
    localparam logic [GAIN_W-1:0] KI_Y_RST  = 24'd6554;
    localparam logic [GAIN_W-1:0] KP_RP_RST = 24'd340787;
    localparam logic [GAIN_W-1:0] KP_Y_RST  = 24'd347341;
    localparam logic [GAIN_W-1:0] KD_RP_RST = 24'd163840;
    localparam logic [GAIN_W-1:0] KD_Y_RST  = 24'd104858;
    localparam logic [GAIN_W-1:0] CROSS_RST = 24'd0;

    // axis codes
    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KI_RP,
        CFG_KI_Y,
        CFG_KP_RP,
        CFG_KP_Y,
        CFG_KD_RP,
        CFG_KD_Y,
        CFG_CROSS
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_INTEG,
        OP_PROD,
        OP_KI,
        OP_KP,
        OP_KD,
        OP_CROSS
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_POST,
        ST_APPLY,
        ST_DONE
    } state_t;

endpackage

[rtl/alqi_mul.sv]
// ----------------------------------------------------------------------------
// alqi_mul
// digit serial unsigned multiplier, one 4-bit digit of the first operand
// per cycle, product bits shifted out lsb first
// ----------------------------------------------------------------------------
module alqi_mul
    import alqi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MAG_M_W-1:0] mag_m,
    input  logic [MAG_G_W-1:0] mag_g,
    output logic               done,
    output logic [PROD_W-1:0]  product
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [DCNT_W-1:0]          cnt_reg, cnt_next;
    logic [MAG_M_W-1:0]         m_reg;
    logic [MAG_G_W-1:0]         g_reg;
    logic [MAG_G_W-1:0]         hi_reg;
    logic [MAG_M_W-1:0]         lo_reg;
    logic [MAG_G_W+DIGIT_W-1:0] step_sum;

    // one digit times the full second operand plus the running high part
    assign step_sum = {{DIGIT_W{1'b0}}, hi_reg}
                    + ({{DIGIT_W{1'b0}}, g_reg} * {{MAG_G_W{1'b0}}, m_reg[DIGIT_W-1:0]});

    // digit counter and done pulse
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(NUM_DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and product shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg  <= mag_m;
            g_reg  <= mag_g;
            hi_reg <= '0;
        end
        else if (busy_reg)
        begin
            m_reg  <= m_reg >> DIGIT_W;
            hi_reg <= step_sum[MAG_G_W+DIGIT_W-1:DIGIT_W];
            lo_reg <= {step_sum[DIGIT_W-1:0], lo_reg[MAG_M_W-1:DIGIT_W]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

[rtl/attitude_lqi_controller.sv]
// ----------------------------------------------------------------------------
// attitude_lqi_controller
// lqr attitude controller with integral action and throttle ramp
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_axis    | in        | angles, rates, targets, step_time (one beat per sample)
//  m_axis    | out       | torques, throttle_level, motors_enabled
//  cfg       | in        | gain register writes, no read-back
//
//  one sample runs 18 products in sequence through one digit serial
//  multiplier, each as a start, the 14 digit steps, a done step, one step to
//  scale and cap and one to accumulate, plus an accept step and a step to
//  load the result register.
//  one sample is in work at a time; s_axis_tready is high only when idle.
//  a finished result waits in the output register while m_axis is stalled.
//  reset sets gains to their defaults, integrals to zero and throttle to 1000.
// ----------------------------------------------------------------------------
module attitude_lqi_controller
    import alqi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, roll_rate, pitch_rate, yaw_rate,
    // roll_target, pitch_target, yaw_target, step_time
    input  logic [IN_W-1:0]       s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // torque_roll, torque_pitch, torque_yaw, throttle_level, motors_enabled, pad
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [1:0] axis_reg, axis_next;
    logic   enable_reg, enable_next;
    logic [THR_W-1:0] thr_reg, thr_next;
    logic   out_valid_reg, out_valid_next;

    logic [GAIN_W-1:0] ki_rp_reg, ki_y_reg, kp_rp_reg, kp_y_reg;
    logic [GAIN_W-1:0] kd_rp_reg, kd_y_reg, cross_reg;

    logic signed [INTEG_W-1:0] integ_reg [3];
    logic signed [ERR_W-1:0]   err_reg [3];
    logic signed [DATA_W-1:0]  rate_reg [3];
    logic [DT_W-1:0]           dt_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   term_reg;
    logic signed [DATA_W-1:0]  torque_reg [3];
    logic                      neg_reg;
    logic [OUT_W-1:0]          out_data_reg;

    logic                      accept;
    logic                      mul_start;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_product;
    logic signed [ACC_W-1:0]   v_sel;
    logic signed [OPND_W-1:0]  g_sel;
    logic [ACC_W-1:0]          v_abs;
    logic [OPND_W-1:0]         g_abs;
    logic [PROD_W-1:0]         scaled;
    logic [PROD_W-1:0]         capped;
    logic [ACC_W-1:0]          term_mag;
    logic signed [ACC_W-1:0]   term_val;
    logic signed [ACC_W-1:0]   integ_sum;
    logic signed [ACC_W-1:0]   integ_sat;
    logic signed [ACC_W-1:0]   torq_sum;
    logic signed [ACC_W-1:0]   torq_sat;
    logic [THR_W-1:0]          thr_step;
    logic [THR_W-1:0]          thr_new;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign mul_start     = (state_reg == ST_START);

    // throttle ramp for the sample being accepted
    always_comb
    begin
        thr_step = thr_reg + THR_STEP;
        thr_new  = thr_reg;
        if (thr_reg < THR_MAX)
        begin
            thr_new = (thr_step > THR_MAX) ? THR_MAX : thr_step;
        end
    end

    // operand selection for the current product
    always_comb
    begin
        v_sel = '0;
        g_sel = '0;
        unique case (op_reg)
            OP_INTEG:
            begin
                g_sel = OPND_W'(dt_reg);
                unique case (axis_reg)
                    AXIS_PITCH: v_sel = ACC_W'(err_reg[1]);
                    AXIS_YAW:   v_sel = ACC_W'(err_reg[2]);
                    default:    v_sel = ACC_W'(err_reg[0]);
                endcase
            end
            OP_PROD:
            begin
                unique case (axis_reg)
                    AXIS_PITCH:
                    begin
                        v_sel = ACC_W'(rate_reg[0]);
                        g_sel = OPND_W'(rate_reg[2]);
                    end
                    AXIS_YAW:
                    begin
                        v_sel = ACC_W'(rate_reg[1]);
                        g_sel = OPND_W'(rate_reg[0]);
                    end
                    default:
                    begin
                        v_sel = ACC_W'(rate_reg[1]);
                        g_sel = OPND_W'(rate_reg[2]);
                    end
                endcase
            end
            OP_KI:
            begin
                unique case (axis_reg)
                    AXIS_PITCH:
                    begin
                        v_sel = ACC_W'(integ_reg[1]);
                        g_sel = OPND_W'(ki_rp_reg);
                    end
                    AXIS_YAW:
                    begin
                        v_sel = ACC_W'(integ_reg[2]);
                        g_sel = OPND_W'(ki_y_reg);
                    end
                    default:
                    begin
                        v_sel = ACC_W'(integ_reg[0]);
                        g_sel = OPND_W'(ki_rp_reg);
                    end
                endcase
            end
            OP_KP:
            begin
                unique case (axis_reg)
                    AXIS_PITCH:
                    begin
                        v_sel = ACC_W'(err_reg[1]);
                        g_sel = OPND_W'(kp_rp_reg);
                    end
                    AXIS_YAW:
                    begin
                        v_sel = ACC_W'(err_reg[2]);
                        g_sel = OPND_W'(kp_y_reg);
                    end
                    default:
                    begin
                        v_sel = ACC_W'(err_reg[0]);
                        g_sel = OPND_W'(kp_rp_reg);
                    end
                endcase
            end
            OP_KD:
            begin
                unique case (axis_reg)
                    AXIS_PITCH:
                    begin
                        v_sel = ACC_W'(rate_reg[1]);
                        g_sel = OPND_W'(kd_rp_reg);
                    end
                    AXIS_YAW:
                    begin
                        v_sel = ACC_W'(rate_reg[2]);
                        g_sel = OPND_W'(kd_y_reg);
                    end
                    default:
                    begin
                        v_sel = ACC_W'(rate_reg[0]);
                        g_sel = OPND_W'(kd_rp_reg);
                    end
                endcase
            end
            OP_CROSS:
            begin
                v_sel = prod_reg;
                g_sel = OPND_W'($signed(cross_reg));
            end
            default:
            begin
                v_sel = '0;
                g_sel = '0;
            end
        endcase
        v_abs = v_sel[ACC_W-1] ? ACC_W'(-v_sel) : ACC_W'(v_sel);
        g_abs = g_sel[OPND_W-1] ? OPND_W'(-g_sel) : OPND_W'(g_sel);
    end

    alqi_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mag_m   (v_abs[MAG_M_W-1:0]),
        .mag_g   (g_abs[MAG_G_W-1:0]),
        .done    (mul_done),
        .product (mul_product)
    );

    // scale, cap and sign of the finished product
    always_comb
    begin
        scaled   = (op_reg == OP_INTEG) ? (mul_product >> DT_FRAC)
                                        : (mul_product >> FRAC_BITS);
        capped   = (scaled > TERM_CAP) ? TERM_CAP : scaled;
        term_mag = {{(ACC_W-TERM_W){1'b0}}, capped[TERM_W-1:0]};
        term_val = neg_reg ? -$signed(term_mag) : $signed(term_mag);
    end

    // integral update and torque sum with saturation
    always_comb
    begin
        unique case (axis_reg)
            AXIS_PITCH: integ_sum = ACC_W'(integ_reg[1]) + term_reg;
            AXIS_YAW:   integ_sum = ACC_W'(integ_reg[2]) + term_reg;
            default:    integ_sum = ACC_W'(integ_reg[0]) + term_reg;
        endcase
        if (integ_sum > INTEG_MAX)
        begin
            integ_sat = INTEG_MAX;
        end
        else if (integ_sum < INTEG_MIN)
        begin
            integ_sat = INTEG_MIN;
        end
        else
        begin
            integ_sat = integ_sum;
        end
        torq_sum = acc_reg - term_reg;
        if (torq_sum > TORQ_MAX)
        begin
            torq_sat = TORQ_MAX;
        end
        else if (torq_sum < TORQ_MIN)
        begin
            torq_sat = TORQ_MIN;
        end
        else
        begin
            torq_sat = torq_sum;
        end
    end

    // sequencer over the product list
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        axis_next      = axis_reg;
        enable_next    = enable_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    thr_next    = thr_new;
                    enable_next = (thr_new > THR_ARM);
                    op_next     = OP_INTEG;
                    axis_next   = AXIS_ROLL;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_START;
                unique case (op_reg)
                    OP_INTEG:
                    begin
                        if (axis_reg == AXIS_YAW)
                        begin
                            axis_next = AXIS_ROLL;
                            op_next   = OP_PROD;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                        end
                    end
                    OP_PROD:  op_next = OP_KI;
                    OP_KI:    op_next = OP_KP;
                    OP_KP:    op_next = OP_KD;
                    OP_KD:    op_next = OP_CROSS;
                    OP_CROSS:
                    begin
                        if (axis_reg == AXIS_YAW)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                            op_next   = OP_PROD;
                        end
                    end
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_INTEG;
            axis_reg      <= AXIS_ROLL;
            enable_reg    <= 1'b0;
            thr_reg       <= THR_START;
            out_valid_reg <= 1'b0;
            ki_rp_reg     <= KI_RP_RST;
            ki_y_reg      <= KI_Y_RST;
            kp_rp_reg     <= KP_RP_RST;
            kp_y_reg      <= KP_Y_RST;
            kd_rp_reg     <= KD_RP_RST;
            kd_y_reg      <= KD_Y_RST;
            cross_reg     <= CROSS_RST;
            integ_reg[0]  <= '0;
            integ_reg[1]  <= '0;
            integ_reg[2]  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            axis_reg      <= axis_next;
            enable_reg    <= enable_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_KI_RP: ki_rp_reg <= cfg_wdata;
                    CFG_KI_Y:  ki_y_reg  <= cfg_wdata;
                    CFG_KP_RP: kp_rp_reg <= cfg_wdata;
                    CFG_KP_Y:  kp_y_reg  <= cfg_wdata;
                    CFG_KD_RP: kd_rp_reg <= cfg_wdata;
                    CFG_KD_Y:  kd_y_reg  <= cfg_wdata;
                    CFG_CROSS: cross_reg <= cfg_wdata;
                    default:   ;
                endcase
            end
            // integral update, cleared at the end of a disarmed sample
            if (state_reg == ST_APPLY && op_reg == OP_INTEG)
            begin
                unique case (axis_reg)
                    AXIS_PITCH: integ_reg[1] <= integ_sat[INTEG_W-1:0];
                    AXIS_YAW:   integ_reg[2] <= integ_sat[INTEG_W-1:0];
                    default:    integ_reg[0] <= integ_sat[INTEG_W-1:0];
                endcase
            end
            else if (state_reg == ST_DONE && state_next == ST_IDLE && !enable_reg)
            begin
                integ_reg[0] <= '0;
                integ_reg[1] <= '0;
                integ_reg[2] <= '0;
            end
        end
    end

    // sample capture, term pipeline and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg[0]  <= ERR_W'($signed(s_axis_tdata[6*DATA_W +: DATA_W]))
                         - ERR_W'($signed(s_axis_tdata[0*DATA_W +: DATA_W]));
            err_reg[1]  <= ERR_W'($signed(s_axis_tdata[7*DATA_W +: DATA_W]))
                         - ERR_W'($signed(s_axis_tdata[1*DATA_W +: DATA_W]));
            err_reg[2]  <= ERR_W'($signed(s_axis_tdata[8*DATA_W +: DATA_W]))
                         - ERR_W'($signed(s_axis_tdata[2*DATA_W +: DATA_W]));
            rate_reg[0] <= s_axis_tdata[3*DATA_W +: DATA_W];
            rate_reg[1] <= s_axis_tdata[4*DATA_W +: DATA_W];
            rate_reg[2] <= s_axis_tdata[5*DATA_W +: DATA_W];
            dt_reg      <= s_axis_tdata[9*DATA_W +: DT_W];
        end
        if (state_reg == ST_START)
        begin
            neg_reg <= v_sel[ACC_W-1] ^ g_sel[OPND_W-1];
        end
        if (state_reg == ST_POST)
        begin
            term_reg <= term_val;
        end
        if (state_reg == ST_APPLY)
        begin
            unique case (op_reg)
                OP_PROD:  prod_reg <= term_reg;
                OP_KI:    acc_reg  <= term_reg;
                OP_KP:    acc_reg  <= acc_reg + term_reg;
                OP_KD:    acc_reg  <= acc_reg - term_reg;
                OP_CROSS:
                begin
                    unique case (axis_reg)
                        AXIS_PITCH: torque_reg[1] <= torq_sat[DATA_W-1:0];
                        AXIS_YAW:   torque_reg[2] <= torq_sat[DATA_W-1:0];
                        default:    torque_reg[0] <= torq_sat[DATA_W-1:0];
                    endcase
                end
                default:  ;
            endcase
        end
        if (state_reg == ST_DONE && state_next == ST_IDLE)
        begin
            out_data_reg <= {{(OUT_W - 3*DATA_W - THR_W - 1){1'b0}}, enable_reg, thr_reg,
                             (enable_reg ? torque_reg[2] : {DATA_W{1'b0}}),
                             (enable_reg ? torque_reg[1] : {DATA_W{1'b0}}),
                             (enable_reg ? torque_reg[0] : {DATA_W{1'b0}})};
        end
    end

endmodule
